// ===== rtl/mt19937_pkg.sv =====
// Package for the MT19937 generator: word and address types, twist/temper
// constants, and the seeding LCG and output tempering functions.
// No dependencies.
package mt19937_pkg;

    localparam int WordW = 32;
    localparam int Words = 624;
    localparam int Shift = 397;
    localparam int AddrW = $clog2(Words);
    localparam int PosW  = 10;

    typedef logic [WordW-1:0] word_t;
    typedef logic [AddrW-1:0] addr_t;
    typedef logic [PosW-1:0]  pos_t;

    localparam word_t TwistXor    = 32'h9908_b0df;
    localparam word_t TemperB     = 32'h9d2c_5680;
    localparam word_t TemperC     = 32'hefc6_0000;
    localparam word_t LcgMul      = 32'd69069;
    localparam word_t DefaultSeed = 32'd4357;

    localparam pos_t  UsedUp      = pos_t'(Words);
    localparam pos_t  NeverSeeded = pos_t'(Words + 1);
    localparam addr_t LastAddr    = addr_t'(Words - 1);

    // One step of the 69069 congruential sequence, modulo 2^32
    function automatic word_t lcg_next(input word_t s);
        word_t prod;
        prod = s * LcgMul;
        return prod + word_t'(1);
    endfunction

    function automatic word_t temper(input word_t y_in);
        word_t y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== rtl/mt19937_in_if.sv =====
// Input channel of the MT19937 generator: action and seed, valid/ready.
// Depends on mt19937_pkg.
interface mt19937_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    mt19937_pkg::word_t   seed_value;

    modport source (output valid, output action, output seed_value, input ready);
    modport sink   (input valid, input action, input seed_value, output ready);
endinterface

// ===== rtl/mt19937_out_if.sv =====
// Output channel of the MT19937 generator: one tempered word, valid/ready.
// Depends on mt19937_pkg.
interface mt19937_out_if;
    logic                 valid;
    logic                 ready;
    mt19937_pkg::word_t   random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/mt19937_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mt19937_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [DATA_W-1:0]        rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [DATA_W-1:0]        rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/mt19937_generator_top.sv =====
// Top level of the MT19937 generator: sequencer, seeding LCG, twist and temper.
// Depends on mt19937_pkg, mt19937_in_if, mt19937_out_if, mt19937_ram.
//
// Usage:
//   item   (sink)   : action 0 seeds the 624-word state from seed_value and
//                     gives no result; action 1 draws one word.
//   result (source) : one tempered 32-bit word per draw.
//   item.ready is high only while the sequencer is idle; one item is worked
//   on at a time.
// Work per item (accept to sequencer idle):
//   seed                  : two LCG multiplies per word, one multiplier
//   draw, state left      : read the word at the read position and temper it
//   draw, state used up   : twist (RAM read ports give the next and far word
//                           each step), then read
//   draw, never seeded    : default seed 4357, twist, then read
// The 624-word state sits in a RAM with no clearing pass; every path seeds
// before it reads. Reset marks the state as never seeded.
// The result register parts the two sides: a new item is taken while a word
// waits; a draw that finishes while the receiver stalls holds in its last
// state until the output register frees.
module mt19937_generator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    mt19937_in_if.sink           item,
    mt19937_out_if.source        result
);

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StSeedA  = 3'd1;
    localparam logic [2:0] StSeedB  = 3'd2;
    localparam logic [2:0] StTwInit = 3'd3;
    localparam logic [2:0] StTwRd   = 3'd4;
    localparam logic [2:0] StTwCalc = 3'd5;
    localparam logic [2:0] StDrRd   = 3'd6;
    localparam logic [2:0] StDrOut  = 3'd7;

    localparam logic [mt19937_pkg::AddrW:0] ShiftExt =
        (mt19937_pkg::AddrW + 1)'(mt19937_pkg::Shift);
    localparam logic [mt19937_pkg::AddrW:0] WordsExt =
        (mt19937_pkg::AddrW + 1)'(mt19937_pkg::Words);

    logic [2:0]                state_reg, state_next;
    mt19937_pkg::pos_t         pos_reg, pos_next;
    mt19937_pkg::addr_t        idx_reg, idx_next;
    logic                      draw_reg, draw_next;
    mt19937_pkg::word_t        lcg_reg, lcg_next;
    logic [15:0]               hi_reg, hi_next;
    mt19937_pkg::word_t        hold_reg, hold_next;
    logic                      out_valid_reg, out_valid_next;
    mt19937_pkg::word_t        out_word_reg, out_word_next;

    logic                      ram_we;
    mt19937_pkg::addr_t        ram_waddr;
    mt19937_pkg::word_t        ram_wdata;
    mt19937_pkg::addr_t        ram_raddr_a;
    mt19937_pkg::addr_t        ram_raddr_b;
    mt19937_pkg::word_t        ram_rdata_a;
    mt19937_pkg::word_t        ram_rdata_b;

    mt19937_pkg::word_t        lcg_step;
    mt19937_pkg::addr_t        nxt_addr;
    logic [mt19937_pkg::AddrW:0] far_sum;
    mt19937_pkg::addr_t        far_addr;
    mt19937_pkg::word_t        twist_y;
    mt19937_pkg::word_t        twist_v;
    logic                      out_free;

    mt19937_ram #(
        .DATA_W (mt19937_pkg::WordW),
        .DEPTH  (mt19937_pkg::Words)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // shared LCG multiplier, always fed from the registered sequence value
    assign lcg_step = mt19937_pkg::lcg_next(lcg_reg);

    assign nxt_addr = (idx_reg == mt19937_pkg::LastAddr) ? '0 : idx_reg + 1'b1;
    assign far_sum  = {1'b0, idx_reg} + ShiftExt;
    assign far_addr = (far_sum >= WordsExt) ? mt19937_pkg::addr_t'(far_sum - WordsExt)
                                            : far_sum[mt19937_pkg::AddrW-1:0];

    // hold_reg carries word[k] (read as the next word of the previous step)
    assign twist_y = {hold_reg[31], ram_rdata_a[30:0]};
    assign twist_v = ram_rdata_b ^ (twist_y >> 1)
                   ^ (twist_y[0] ? mt19937_pkg::TwistXor : '0);

    assign out_free = !out_valid_reg || result.ready;

    assign item.ready         = (state_reg == StIdle);
    assign result.valid       = out_valid_reg;
    assign result.random_word = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        draw_next      = draw_reg;
        lcg_next       = lcg_reg;
        hi_next        = hi_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = twist_v;
        ram_raddr_a    = nxt_addr;
        ram_raddr_b    = far_addr;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            StIdle:
            begin
                if (item.valid)
                begin
                    idx_next  = '0;
                    draw_next = item.action;
                    if (!item.action)
                    begin
                        lcg_next   = item.seed_value;
                        state_next = StSeedA;
                    end
                    else if (pos_reg == mt19937_pkg::NeverSeeded)
                    begin
                        lcg_next   = mt19937_pkg::DefaultSeed;
                        state_next = StSeedA;
                    end
                    else if (pos_reg >= mt19937_pkg::UsedUp)
                    begin
                        state_next = StTwInit;
                    end
                    else
                    begin
                        state_next = StDrRd;
                    end
                end
            end
            StSeedA:
            begin
                hi_next    = lcg_reg[31:16];
                lcg_next   = lcg_step;
                state_next = StSeedB;
            end
            StSeedB:
            begin
                ram_we    = 1'b1;
                ram_wdata = {hi_reg, lcg_reg[31:16]};
                lcg_next  = lcg_step;
                if (idx_reg == mt19937_pkg::LastAddr)
                begin
                    idx_next   = '0;
                    pos_next   = mt19937_pkg::UsedUp;
                    state_next = draw_reg ? StTwInit : StIdle;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = StSeedA;
                end
            end
            StTwInit:
            begin
                ram_raddr_a = '0;
                state_next  = StTwRd;
            end
            StTwRd:
            begin
                // on the first step the port still shows word 0
                if (idx_reg == '0)
                begin
                    hold_next = ram_rdata_a;
                end
                state_next = StTwCalc;
            end
            StTwCalc:
            begin
                ram_we    = 1'b1;
                hold_next = ram_rdata_a;
                if (idx_reg == mt19937_pkg::LastAddr)
                begin
                    idx_next   = '0;
                    pos_next   = '0;
                    state_next = StDrRd;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = StTwRd;
                end
            end
            StDrRd:
            begin
                ram_raddr_a = pos_reg[mt19937_pkg::AddrW-1:0];
                state_next  = StDrOut;
            end
            StDrOut:
            begin
                ram_raddr_a = pos_reg[mt19937_pkg::AddrW-1:0];
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = mt19937_pkg::temper(ram_rdata_a);
                    pos_next       = pos_reg + 1'b1;
                    state_next     = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            pos_reg       <= mt19937_pkg::NeverSeeded;
            idx_reg       <= '0;
            draw_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg      <= lcg_next;
        hi_reg       <= hi_next;
        hold_reg     <= hold_next;
        out_word_reg <= out_word_next;
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= mt19937_pkg::NeverSeeded)
        else $error("read position out of range");

    a_draw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StDrRd) |-> (pos_reg < mt19937_pkg::UsedUp))
        else $error("draw read with state used up");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == StSeedB || state_reg == StTwCalc))
        else $error("RAM write outside seed or twist");

    a_twist_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StTwCalc && idx_reg == mt19937_pkg::LastAddr)
        |=> (pos_reg == '0 && state_reg == StDrRd))
        else $error("twist did not rewind read position");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StDrOut && out_valid_reg && !result.ready)
        |=> (state_reg == StDrOut && $stable(pos_reg)))
        else $error("draw finished over a waiting result");
`endif

endmodule
